>>> rtl/frsa_pkg.sv
// ---------------------------------------------------------------------------
// frsa_pkg - shared types and constants of the frame rms and spectrum analyzer
// twiddle table, state encoding, field widths
// ---------------------------------------------------------------------------
package frsa_pkg;

   localparam int N_PTS      = 64;
   localparam int LOG_N      = 6;
   localparam int IDX_W      = 6;
   localparam int HALF_N     = 32;
   localparam int DATA_W     = 32;
   localparam int AMP_W      = 21;
   localparam int ID_W       = 16;
   localparam int BIN_W      = 5;
   localparam int FREQ_W     = 15;
   localparam int SAMPLE_MAX = 4095;

   localparam logic [1:0] CSR_MIDSCALE  = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_BIN_WIDTH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RMS_START,
      ST_RMS_WAIT,
      ST_BF_READ,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WRITE,
      ST_OUT_READ,
      ST_OUT_SQ,
      ST_OUT_SQRT,
      ST_OUT_WAIT,
      ST_OUT_SEND
   } state_type;

   // q30 cosine and sine of 2*pi*m/64, m = 0..31
   function automatic logic signed [31:0] tw_cos(input logic [4:0] m);
      logic signed [31:0] r;
      case (m)
         5'd0:  r = 32'sd1073741824;
         5'd1:  r = 32'sd1068571464;
         5'd2:  r = 32'sd1053110176;
         5'd3:  r = 32'sd1027506861;
         5'd4:  r = 32'sd992008094;
         5'd5:  r = 32'sd946955747;
         5'd6:  r = 32'sd892783698;
         5'd7:  r = 32'sd830013654;
         5'd8:  r = 32'sd759250125;
         5'd9:  r = 32'sd681174602;
         5'd10: r = 32'sd596538995;
         5'd11: r = 32'sd506158392;
         5'd12: r = 32'sd410903207;
         5'd13: r = 32'sd311690799;
         5'd14: r = 32'sd209476638;
         5'd15: r = 32'sd105245103;
         5'd16: r = 32'sd0;
         5'd17: r = -32'sd105245103;
         5'd18: r = -32'sd209476638;
         5'd19: r = -32'sd311690799;
         5'd20: r = -32'sd410903207;
         5'd21: r = -32'sd506158392;
         5'd22: r = -32'sd596538995;
         5'd23: r = -32'sd681174602;
         5'd24: r = -32'sd759250125;
         5'd25: r = -32'sd830013654;
         5'd26: r = -32'sd892783698;
         5'd27: r = -32'sd946955747;
         5'd28: r = -32'sd992008094;
         5'd29: r = -32'sd1027506861;
         5'd30: r = -32'sd1053110176;
         default: r = -32'sd1068571464;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] tw_sin(input logic [4:0] m);
      logic signed [31:0] r;
      logic [4:0] mm;
      mm = (m > 5'd16) ? (5'd0 - m) : m;
      case (mm)
         5'd0:  r = 32'sd0;
         5'd1:  r = 32'sd105245103;
         5'd2:  r = 32'sd209476638;
         5'd3:  r = 32'sd311690799;
         5'd4:  r = 32'sd410903207;
         5'd5:  r = 32'sd506158392;
         5'd6:  r = 32'sd596538995;
         5'd7:  r = 32'sd681174602;
         5'd8:  r = 32'sd759250125;
         5'd9:  r = 32'sd830013654;
         5'd10: r = 32'sd892783698;
         5'd11: r = 32'sd946955747;
         5'd12: r = 32'sd992008094;
         5'd13: r = 32'sd1027506861;
         5'd14: r = 32'sd1053110176;
         5'd15: r = 32'sd1068571464;
         default: r = 32'sd1073741824;
      endcase
      return r;
   endfunction

   // control from sequencer to datapath
   typedef struct packed {
      logic sqrt_start;
      logic rms_sel;
   } ctl_type;

endpackage

>>> rtl/frsa_sqrt.sv
// ---------------------------------------------------------------------------
// frsa_sqrt - iterative rounded square root
// one result bit per cycle over a 42-bit radicand, rounds half up
// ---------------------------------------------------------------------------
module frsa_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [41:0] radicand,
   output logic        done,
   output logic [21:0] root
);

   logic [41:0] rem_ff, rem_in;
   logic [20:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [41:0] rad_ff, rad_in;
   logic [43:0] trial;
   logic [43:0] cur;

   // restoring square root, two radicand bits per step
   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rad_in  = rad_ff;
      done_in = 1'b0;
      cur     = {rem_ff, rad_ff[41:40]};
      trial   = {21'd0, q_ff, 2'b01};
      if (start) begin
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
         rad_in  = radicand;
      end else if (busy_ff) begin
         rad_in = {rad_ff[39:0], 2'b00};
         if (cur >= trial) begin
            rem_in = 42'(cur - trial);
            q_in   = {q_ff[19:0], 1'b1};
         end else begin
            rem_in = 42'(cur);
            q_in   = {q_ff[19:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd20) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      rad_ff <= rad_in;
   end

   // remainder above root means the fraction is past one half
   assign done = done_ff;
   assign root = (rem_ff > {21'd0, q_ff}) ? (22'(q_ff) + 22'd1) : 22'(q_ff);

endmodule

>>> rtl/frame_rms_and_spectrum_analyzer_unit.sv
// ---------------------------------------------------------------------------
// frame_rms_and_spectrum_analyzer_unit - rms and 64-point spectrum of a frame
// collects a frame, runs an in-place fft and streams 32 bin results
// ---------------------------------------------------------------------------
// A frame is one id word then 64 sample words, taken while the block is
// idle. After the last sample the block is busy: the rms square root, 192
// butterflies on one shared complex multiplier (reads of a and b, multiply,
// round, writes of a and b), and 32 bins through the shared square root
// unit (reads, squares and their sum, sqrt start, sqrt wait, send); each
// bin waits in send while the output stalls.
module frame_rms_and_spectrum_analyzer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // frame_id, rms_q8, bin_index, frequency_hz, amplitude_q8
   output logic        rsp_tuser,   // above_threshold
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   frsa_pkg::state_type st_ff, st_in;

   logic [11:0] mid_ff;
   logic [20:0] thr_ff;
   logic [9:0]  bw_ff;

   logic [6:0]  wc_ff, wc_in;
   logic [15:0] id_ff, id_in;
   logic [29:0] sq_ff, sq_in;
   logic [20:0] rms_ff, rms_in;

   logic signed [31:0] mre [frsa_pkg::N_PTS];
   logic signed [31:0] mim [frsa_pkg::N_PTS];
   logic        we;
   logic [5:0]  waddr, raddr;
   logic signed [31:0] wre, wim;
   logic signed [31:0] rre_ff, rim_ff;

   logic [2:0]  stage_ff, stage_in;
   logic [4:0]  bf_ff, bf_in;
   logic [1:0]  sub_ff, sub_in;
   logic signed [31:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [31:0] ar_in, ai_in, br_in, bi_in;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [31:0] tr_ff, ti_ff, tr_in, ti_in;
   logic [4:0]  k_ff, k_in;
   logic [63:0] m2_ff, m2_in;

   logic        sq_start;
   logic [41:0] sq_rad;
   logic        sq_done;
   logic [21:0] sq_root;
   logic [20:0] amp_ff, amp_in;
   logic        ov_ff, ov_in;

   logic [5:0]  span_i, ia, ib;
   logic [4:0]  tw_m;
   logic signed [31:0] cs, sn;
   logic [11:0] samp;
   logic signed [12:0] cen;
   logic signed [66:0] sr, si;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 12'd2048;
         thr_ff <= 21'd19059;
         bw_ff  <= 10'd60;
      end else if (csr_we) begin
         case (csr_index)
            frsa_pkg::CSR_MIDSCALE:  mid_ff <= csr_wdata[11:0];
            frsa_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata;
            frsa_pkg::CSR_BIN_WIDTH: bw_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // butterfly addressing: pairs ia/ib at distance 2^stage
   always_comb begin
      span_i = 6'(1) << stage_ff;
      ia = 6'(((12'(bf_ff) >> stage_ff) << (stage_ff + 3'd1))
           | (12'(bf_ff) & 12'(span_i - 6'd1)));
      ib = ia | span_i;
      tw_m = 5'((12'(bf_ff) & 12'(span_i - 6'd1)) << (3'd5 - stage_ff));
      cs = frsa_pkg::tw_cos(tw_m);
      sn = frsa_pkg::tw_sin(tw_m);
      samp = (req_tdata > 16'(frsa_pkg::SAMPLE_MAX)) ? 12'hFFF : req_tdata[11:0];
      cen  = $signed({1'b0, samp}) - $signed({1'b0, mid_ff});
      sr = 67'(p0_ff) + 67'(p1_ff);
      si = 67'(p2_ff) - 67'(p3_ff);
   end

   function automatic logic signed [31:0] rnd30(input logic signed [66:0] v);
      logic [66:0] a;
      a = v[66] ? 67'(-v) : 67'(v);
      a = (a + 67'(1 << 29)) >> 30;
      return v[66] ? -32'(a) : 32'(a);
   endfunction

   function automatic logic [5:0] bit_rev(input logic [5:0] v);
      logic [5:0] r;
      for (int j = 0; j < 6; j++) r[j] = v[5 - j];
      return r;
   endfunction

   // sequencer
   always_comb begin
      st_in = st_ff; wc_in = wc_ff; id_in = id_ff; sq_in = sq_ff; rms_in = rms_ff;
      stage_in = stage_ff; bf_in = bf_ff; sub_in = sub_ff;
      ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      tr_in = tr_ff; ti_in = ti_ff; k_in = k_ff; m2_in = m2_ff;
      amp_in = amp_ff; ov_in = ov_ff;
      we = 1'b0; waddr = ia; wre = '0; wim = '0; raddr = ia;
      sq_start = 1'b0; sq_rad = '0;
      req_tready = 1'b0;
      case (st_ff)
         frsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (wc_ff == 7'd0) begin
                  id_in = req_tdata; sq_in = '0; wc_in = 7'd1;
               end else begin
                  we = 1'b1; waddr = 6'(bit_rev(6'(wc_ff - 7'd1)));
                  wre = 32'(cen) <<< 8; wim = '0;
                  sq_in = sq_ff + 30'(26'($signed(cen) * $signed(cen)));
                  if (wc_ff == 7'd64) begin
                     wc_in = 7'd0; st_in = frsa_pkg::ST_RMS_START;
                  end else wc_in = wc_ff + 7'd1;
               end
            end
         end
         frsa_pkg::ST_RMS_START: begin
            sq_start = 1'b1;
            sq_rad = 42'({sq_ff, 16'd0} >> frsa_pkg::LOG_N);
            st_in = frsa_pkg::ST_RMS_WAIT;
         end
         frsa_pkg::ST_RMS_WAIT: begin
            if (sq_done) begin
               rms_in = sq_root[21] ? 21'h1FFFFF : sq_root[20:0];
               stage_in = '0; bf_in = '0; sub_in = '0;
               st_in = frsa_pkg::ST_BF_READ;
            end
         end
         frsa_pkg::ST_BF_READ: begin
            // two reads: a at ia then b at ib
            if (sub_ff == 2'd0) begin
               raddr = ia; sub_in = 2'd1;
            end else if (sub_ff == 2'd1) begin
               raddr = ib; ar_in = rre_ff; ai_in = rim_ff; sub_in = 2'd2;
            end else begin
               br_in = rre_ff; bi_in = rim_ff; sub_in = 2'd0;
               st_in = frsa_pkg::ST_BF_MUL;
            end
         end
         frsa_pkg::ST_BF_MUL: st_in = frsa_pkg::ST_BF_SUM;
         frsa_pkg::ST_BF_SUM: begin
            tr_in = rnd30(sr); ti_in = rnd30(si);
            st_in = frsa_pkg::ST_BF_WRITE;
         end
         frsa_pkg::ST_BF_WRITE: begin
            we = 1'b1;
            if (sub_ff == 2'd0) begin
               waddr = ia; wre = ar_ff + tr_ff; wim = ai_ff + ti_ff; sub_in = 2'd1;
            end else begin
               waddr = ib; wre = ar_ff - tr_ff; wim = ai_ff - ti_ff; sub_in = 2'd0;
               bf_in = bf_ff + 5'd1;
               st_in = frsa_pkg::ST_BF_READ;
               if (bf_ff == 5'd31) begin
                  bf_in = '0;
                  if (stage_ff == 3'(frsa_pkg::LOG_N - 1)) begin
                     k_in = '0; st_in = frsa_pkg::ST_OUT_READ;
                  end else stage_in = stage_ff + 3'd1;
               end
            end
         end
         frsa_pkg::ST_OUT_READ: begin
            raddr = 6'(k_ff);
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               sub_in = 2'd0; br_in = rre_ff; bi_in = rim_ff;
               st_in = frsa_pkg::ST_OUT_SQ;
            end
         end
         frsa_pkg::ST_OUT_SQ: begin
            // the first step squares the bin, the second takes the sum
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else begin
               sub_in = 2'd0;
               m2_in = 64'(p0_ff + p2_ff);
               st_in = frsa_pkg::ST_OUT_SQRT;
            end
         end
         frsa_pkg::ST_OUT_SQRT: begin
            // 4*m2/64^2 = m2 >> 10
            sq_start = 1'b1; sq_rad = 42'(m2_ff >> 10);
            st_in = frsa_pkg::ST_OUT_WAIT;
         end
         frsa_pkg::ST_OUT_WAIT: begin
            if (sq_done) begin
               amp_in = sq_root[21] ? 21'h1FFFFF : sq_root[20:0];
               ov_in = 1'b1;
               st_in = frsa_pkg::ST_OUT_SEND;
            end
         end
         frsa_pkg::ST_OUT_SEND: begin
            if (rsp_tready) begin
               ov_in = 1'b0;
               k_in = k_ff + 5'd1;
               st_in = (k_ff == 5'd31) ? frsa_pkg::ST_IDLE : frsa_pkg::ST_OUT_READ;
            end
         end
         default: st_in = frsa_pkg::ST_IDLE;
      endcase
   end

   // shared complex multiplier, also squares for magnitude
   always_ff @(posedge clock) begin
      if (st_ff == frsa_pkg::ST_BF_MUL) begin
         p0_ff <= cs * br_ff; p1_ff <= sn * bi_ff;
         p2_ff <= cs * bi_ff; p3_ff <= sn * br_ff;
      end else begin
         p0_ff <= br_ff * br_ff; p2_ff <= bi_ff * bi_ff;
         p1_ff <= '0; p3_ff <= '0;
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (we) begin
         mre[waddr] <= wre;
         mim[waddr] <= wim;
      end
      rre_ff <= mre[raddr];
      rim_ff <= mim[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= frsa_pkg::ST_IDLE;
         wc_ff <= '0; id_ff <= '0; sq_ff <= '0; ov_ff <= 1'b0;
         sub_ff <= '0; stage_ff <= '0; bf_ff <= '0; k_ff <= '0;
      end else begin
         st_ff <= st_in; wc_ff <= wc_in; id_ff <= id_in; sq_ff <= sq_in;
         ov_ff <= ov_in; sub_ff <= sub_in; stage_ff <= stage_in;
         bf_ff <= bf_in; k_ff <= k_in;
      end
      rms_ff <= rms_in;
      ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      tr_ff <= tr_in; ti_ff <= ti_in; m2_ff <= m2_in; amp_ff <= amp_in;
   end

   frsa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   // result word
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, amp_ff, 15'(25'(k_ff) * 25'(bw_ff)), k_ff, rms_ff, id_ff};
   assign rsp_tuser  = amp_ff > thr_ff;
   assign rsp_tlast  = k_ff == 5'd31;

endmodule
